// ===== rtl/ads_pkg.sv =====
package ads_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W = 32;
  localparam int DIFF_W   = SAMPLE_W + 3;
  localparam int PROD_W   = SAMPLE_W + DIFF_W;
  localparam int ACC_W    = PROD_W + 2;

  localparam int FIFO_DEPTH = 8;

  localparam logic [2:0] REG_DIFF_X = 3'd0;
  localparam logic [2:0] REG_DIFF_Y = 3'd1;
  localparam logic [2:0] REG_ADV_X  = 3'd2;
  localparam logic [2:0] REG_ADV_Y  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lf;
    logic signed [SAMPLE_W-1:0] ce;
    logic signed [SAMPLE_W-1:0] rt;
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] dn;
  } cross_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] diff_x;
    logic signed [SAMPLE_W-1:0] diff_y;
    logic signed [SAMPLE_W-1:0] adv_x;
    logic signed [SAMPLE_W-1:0] adv_y;
  } coef_t;

  typedef struct packed {
    logic                       last;
    logic signed [SAMPLE_W-1:0] rhs;
  } result_t;

endpackage

// ===== rtl/ads_line_buf.sv =====
module ads_line_buf #(
  parameter int MAX_WIDTH = ads_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [ads_pkg::SAMPLE_W-1:0]  wr_sample,
  output logic [ads_pkg::SAMPLE_W-1:0]  upper,
  output logic [ads_pkg::SAMPLE_W-1:0]  middle
);

  logic [2*ads_pkg::SAMPLE_W-1:0] mem [MAX_WIDTH];
  logic [2*ads_pkg::SAMPLE_W-1:0] rd_data;

  assign upper  = rd_data[2*ads_pkg::SAMPLE_W-1:ads_pkg::SAMPLE_W];
  assign middle = rd_data[ads_pkg::SAMPLE_W-1:0];

  // The middle row moves up and the new sample becomes the middle row.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= {middle, wr_sample};
    end
  end

endmodule

// ===== rtl/ads_rhs_core.sv =====
module ads_rhs_core #(
  parameter int FRAC_BITS = ads_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  input  ads_pkg::cross_t  win,
  input  ads_pkg::coef_t   coef,
  output logic             out_valid,
  output ads_pkg::result_t out_res
);

  localparam int DW = ads_pkg::DIFF_W;
  localparam int PW = ads_pkg::PROD_W;
  localparam int AW = ads_pkg::ACC_W;
  localparam int SW = ads_pkg::SAMPLE_W;

  logic                 v2, v3, v4;
  logic                 l2, l3, l4;
  logic signed [DW-1:0] dxx, dyy, nax, nay;
  logic signed [PW-1:0] p0, p1, p2, p3;
  logic signed [PW:0]   s01, s23;
  logic signed [DW-1:0] lf, ce, rt, up, dn;
  logic signed [AW-1:0] acc, shifted;
  logic signed [SW-1:0] sat;

  assign lf = DW'(win.lf);
  assign ce = DW'(win.ce);
  assign rt = DW'(win.rt);
  assign up = DW'(win.up);
  assign dn = DW'(win.dn);

  assign acc     = AW'(s01) + AW'(s23);
  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    if (shifted[AW-1]) begin
      sat = (&shifted[AW-1:SW-1]) ? shifted[SW-1:0] : {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = (|shifted[AW-1:SW-1]) ? {1'b0, {(SW-1){1'b1}}} : shifted[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v2        <= in_valid;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
    l2 <= in_last;
    l3 <= l2;
    l4 <= l3;
    dxx <= lf + rt - (ce <<< 1);
    dyy <= up + dn - (ce <<< 1);
    // Advection terms enter with a minus sign, so the difference is negated here.
    nax <= (coef.adv_x > 0) ? (lf - ce) : (ce - rt);
    nay <= (coef.adv_y > 0) ? (up - ce) : (ce - dn);
    p0  <= PW'(coef.diff_x) * PW'(dxx);
    p1  <= PW'(coef.diff_y) * PW'(dyy);
    p2  <= PW'(coef.adv_x) * PW'(nax);
    p3  <= PW'(coef.adv_y) * PW'(nay);
    s01 <= (PW+1)'(p0) + (PW+1)'(p1);
    s23 <= (PW+1)'(p2) + (PW+1)'(p3);
    out_res.rhs  <= sat;
    out_res.last <= l4;
  end

endmodule

// ===== rtl/ads_out_fifo.sv =====
module ads_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ads_pkg::result_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output ads_pkg::result_t rd_data
);

  localparam int PTR_W = $clog2(ads_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(ads_pkg::FIFO_DEPTH + 1);

  ads_pkg::result_t mem [ads_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(ads_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ads_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(pop);
    end
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/advection_diffusion_stencil.sv =====
// Accepts one sample per cycle while pending results leave room in the output
// FIFO; a result leaves on m_axis after the sample one row below and one column
// right of its cell is accepted. The rate rests on separate line buffer read
// and write ports and a fully pipelined multiply and sum path. Reset
// (synchronous) clears positions, cross window, coefficients and queues, sets
// width and height to 1024; line buffers are not cleared and need not be.
module advection_diffusion_stencil #(
  parameter int MAX_WIDTH = ads_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = ads_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // rhs_value
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int PEND_W = $clog2(ads_pkg::FIFO_DEPTH + 1);
  localparam int SW    = ads_pkg::SAMPLE_W;

  ads_pkg::coef_t   coef;
  logic [10:0]      padded_width;
  logic [15:0]      padded_height;

  logic [CW-1:0]    col;
  logic [15:0]      row;
  logic [WW-1:0]    pw_ext;
  logic [CW:0]      w_eff, col_ext;
  logic [15:0]      h_eff;
  logic             accept, produce, is_last;

  logic             s1_valid, s1_produce, s1_last;
  logic [CW-1:0]    s1_idx;
  logic [SW-1:0]    s1_sample;
  logic [SW-1:0]    lb_upper, lb_middle;

  logic [SW-1:0]    cw1, cw2, cw4, cw5;
  ads_pkg::cross_t  win;
  logic             win_valid, win_last;

  logic             core_valid;
  ads_pkg::result_t core_res, fifo_res;
  logic [PEND_W-1:0] pend;
  logic             pop;

  assign cfg_ready = 1'b1;

  assign pw_ext  = WW'(padded_width);
  assign w_eff   = (pw_ext < WW'(3)) ? (CW+1)'(3) :
                   (pw_ext > WW'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(pw_ext);
  assign h_eff   = (padded_height < 16'd3) ? 16'd3 : padded_height;
  assign col_ext = (CW+1)'(col);

  assign s_axis_tready = (pend < PEND_W'(ads_pkg::FIFO_DEPTH));
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign produce = (col_ext >= (CW+1)'(2)) && (row >= 16'd2) &&
                   (col_ext < w_eff) && (row < h_eff);
  assign is_last = (col_ext == w_eff - 1'b1) && (row == h_eff - 1'b1);
  assign pop     = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef          <= '0;
      padded_width  <= 11'd1024;
      padded_height <= 16'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        ads_pkg::REG_DIFF_X: coef.diff_x  <= cfg_data;
        ads_pkg::REG_DIFF_Y: coef.diff_y  <= cfg_data;
        ads_pkg::REG_ADV_X:  coef.adv_x   <= cfg_data;
        ads_pkg::REG_ADV_Y:  coef.adv_y   <= cfg_data;
        ads_pkg::REG_WIDTH:  padded_width <= cfg_data[10:0];
        ads_pkg::REG_HEIGHT: padded_height <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      s1_valid   <= 1'b0;
      s1_produce <= 1'b0;
      win_valid  <= 1'b0;
      cw1        <= '0;
      cw2        <= '0;
      cw4        <= '0;
      cw5        <= '0;
      pend       <= '0;
    end else begin
      s1_valid   <= accept;
      s1_produce <= accept && produce;
      win_valid  <= s1_valid && s1_produce;
      if (accept) begin
        if ((col_ext + 1'b1) >= w_eff) begin
          col <= '0;
          row <= ({1'b0, row} + 17'd1 >= {1'b0, h_eff}) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (s1_valid) begin
        cw1 <= cw2;
        cw2 <= lb_middle;
        cw4 <= lb_upper;
        cw5 <= s1_sample;
      end
      pend <= pend + PEND_W'(accept && produce) - PEND_W'(pop);
    end
    s1_idx    <= col;
    s1_sample <= s_axis_tdata;
    s1_last   <= is_last;
    win.lf    <= cw1;
    win.ce    <= cw2;
    win.rt    <= lb_middle;
    win.up    <= cw4;
    win.dn    <= cw5;
    win_last  <= s1_last;
  end

  ads_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col),
    .wr_en     (s1_valid),
    .wr_addr   (s1_idx),
    .wr_sample (s1_sample),
    .upper     (lb_upper),
    .middle    (lb_middle)
  );

  ads_rhs_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rhs_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_last   (win_last),
    .win       (win),
    .coef      (coef),
    .out_valid (core_valid),
    .out_res   (core_res)
  );

  ads_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (core_valid),
    .wr_data  (core_res),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (fifo_res)
  );

  assign m_axis_tdata = fifo_res.rhs;
  assign m_axis_tlast = fifo_res.last;

endmodule

// ===== tb/sv/advection_diffusion_stencil_tb.sv =====
module advection_diffusion_stencil_tb;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int LINE_DEPTH = ads_pkg::MAX_WIDTH_DEF;
  localparam int SHIFT = ads_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 250;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;

  class stencil_scoreboard;
    logic [31:0] upper_row [LINE_DEPTH];
    logic [31:0] middle_row [LINE_DEPTH];
    logic [31:0] win [6];
    int unsigned col, row;
    int coef_dx, coef_dy, coef_ax, coef_ay;
    int unsigned width_reg, height_reg;
    ads_pkg::result_t rhs_queue [$];
    int errors, checked, samples, writes;

    function new();
      foreach (upper_row[k]) begin
        upper_row[k] = '0;
        middle_row[k] = '0;
      end
      foreach (win[k]) win[k] = '0;
      col = 0;
      row = 0;
      coef_dx = 0;
      coef_dy = 0;
      coef_ax = 0;
      coef_ay = 0;
      width_reg = 1024;
      height_reg = 1024;
      errors = 0;
      checked = 0;
      samples = 0;
      writes = 0;
    endfunction

    function int unsigned clamp_width(int unsigned raw);
      if (raw < 3) return 3;
      if (raw > LINE_DEPTH) return LINE_DEPTH;
      return raw;
    endfunction

    function int unsigned clamp_height(int unsigned raw);
      return (raw < 3) ? 3 : raw;
    endfunction

    function int unsigned frame_size();
      return clamp_width(width_reg) * clamp_height(height_reg);
    endfunction

    // Beats still needed to bring the raster position back to the frame origin.
    function int unsigned frame_remainder();
      int unsigned w, h, n;
      w = clamp_width(width_reg);
      h = clamp_height(height_reg);
      n = (col >= w) ? 1 : w - col;
      if (row + 1 < h) n += (h - row - 1) * w;
      return n;
    endfunction

    function int pending();
      return rhs_queue.size();
    endfunction

    function void apply_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        ads_pkg::REG_DIFF_X: coef_dx = v;
        ads_pkg::REG_DIFF_Y: coef_dy = v;
        ads_pkg::REG_ADV_X:  coef_ax = v;
        ads_pkg::REG_ADV_Y:  coef_ay = v;
        ads_pkg::REG_WIDTH:  width_reg = v[10:0];
        ads_pkg::REG_HEIGHT: height_reg = v[15:0];
        default: ;
      endcase
      writes++;
    endfunction

    function logic signed [95:0] wide_product(int k, longint d);
      logic signed [95:0] a, b;
      a = k;
      b = d;
      return a * b;
    endfunction

    function void note_sample(logic [31:0] s);
      int unsigned w, h, c, r, i;
      logic [31:0] below;
      longint lf, ce, rt, up, dn, slope_x, slope_y;
      logic signed [95:0] acc, q;
      ads_pkg::result_t res;
      w = clamp_width(width_reg);
      h = clamp_height(height_reg);
      c = col;
      r = row;
      i = c % LINE_DEPTH;
      below = win[5];
      win[0] = win[1];
      win[1] = win[2];
      win[2] = middle_row[i];
      win[3] = win[4];
      win[4] = upper_row[i];
      win[5] = s;
      upper_row[i] = middle_row[i];
      middle_row[i] = s;
      samples++;
      if (c >= 2 && r >= 2 && c < w && r < h) begin
        lf = $signed(win[0]);
        ce = $signed(win[1]);
        rt = $signed(win[2]);
        up = $signed(win[3]);
        dn = $signed(below);
        slope_x = (coef_ax > 0) ? ce - lf : rt - ce;
        slope_y = (coef_ay > 0) ? ce - up : dn - ce;
        acc = wide_product(coef_dx, lf - 2 * ce + rt)
            + wide_product(coef_dy, up - 2 * ce + dn)
            - wide_product(coef_ax, slope_x)
            - wide_product(coef_ay, slope_y);
        q = acc >>> SHIFT;
        if (q > 96'sh7fff_ffff) res.rhs = S_MAX;
        else if (q < -96'sh8000_0000) res.rhs = S_MIN;
        else res.rhs = q[31:0];
        res.last = (c == w - 1 && r == h - 1);
        rhs_queue.push_back(res);
      end
      if (c + 1 >= w) begin
        col = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_result(logic [31:0] rhs, logic last);
      ads_pkg::result_t want;
      if (rhs_queue.size() == 0) begin
        $error("unexpected result beat: rhs_value %h last_of_frame %b", rhs, last);
        errors++;
        return;
      end
      want = rhs_queue.pop_front();
      checked++;
      if (rhs !== want.rhs) begin
        $error("rhs_value mismatch: expected %h, actual %h", want.rhs, rhs);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_frame mismatch: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // rhs_value
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        steady = 1'b0;
  int          random_items = 0;

  stencil_scoreboard sb;

  advection_diffusion_stencil uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit hold_off();
    return !steady && ($urandom_range(0, 99) < 11);
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 11))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return S_MIN;
      1: return S_MAX;
      2, 3, 4, 5, 6: return $urandom;
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  // Geometry registers only keep their low bits; the rest is filled with noise.
  function automatic logic [31:0] geometry_word(logic [2:0] idx, int unsigned raw);
    logic [31:0] v;
    v = $urandom;
    if (idx == ads_pkg::REG_WIDTH) v[10:0] = raw[10:0];
    else v[15:0] = raw[15:0];
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= !hold_off();
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, v);
  endtask

  task automatic set_all(input logic [31:0] dx, dy, ax, ay, input int unsigned w, h);
    write_reg(ads_pkg::REG_DIFF_X, dx);
    write_reg(ads_pkg::REG_DIFF_Y, dy);
    write_reg(ads_pkg::REG_ADV_X, ax);
    write_reg(ads_pkg::REG_ADV_Y, ay);
    write_reg(ads_pkg::REG_WIDTH, geometry_word(ads_pkg::REG_WIDTH, w));
    write_reg(ads_pkg::REG_HEIGHT, geometry_word(ads_pkg::REG_HEIGHT, h));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] s);
    while (hold_off()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(s);
  endtask

  task automatic feed(input int unsigned n);
    repeat (n) send_sample(pick_sample());
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic run_grid(input logic [31:0] g [9]);
    foreach (g[k]) send_sample(g[k]);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] grid [9];
    int unsigned n, w;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry, then a width cut below the current column mid-frame.
    feed(LINE_DEPTH / 8);
    wait_idle();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 4, 5);
    feed(sb.frame_remainder());
    wait_idle();

    // Minimal grids: extreme coefficients and samples with clamped geometry, then a plain 3x3 grid.
    set_all(S_MAX, S_MAX, S_MIN, S_MAX, 0, 1);
    grid = '{32'h0, S_MIN, 32'hffff_ffff, S_MIN, S_MAX, S_MIN, 32'h1, S_MIN, 32'h0};
    run_grid(grid);
    wait_idle();
    set_all(S_MIN, S_MIN, S_MAX, S_MIN, 1, 2);
    grid = '{S_MAX, S_MAX, 32'h0, S_MAX, S_MIN, S_MAX, 32'hffff_ffff, S_MAX, S_MIN};
    run_grid(grid);
    wait_idle();
    set_all(32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0, 3, 3);
    grid = '{32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'h0000_4000, 32'h0005_0000,
             32'hfffe_0000, 32'h0007_0000, 32'h0001_8000, 32'h0000_0001};
    run_grid(grid);
    wait_idle();

    // Tallest height, cut short mid-frame.
    set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 3, 65535);
    feed(36);
    wait_idle();
    set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 3, 4);
    feed(sb.frame_remainder());
    wait_idle();

    // Oversized width cut down mid-row, then the rest of that frame with no idling on either side.
    steady <= 1'b1;
    set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 2047, 3);
    feed(100);
    wait_idle();
    set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 40, 6);
    feed(sb.frame_remainder());
    wait_idle();
    steady <= 1'b0;

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) write_reg(ads_pkg::REG_DIFF_X, pick_coef());
      if ($urandom_range(0, 2) != 0) write_reg(ads_pkg::REG_DIFF_Y, pick_coef());
      if ($urandom_range(0, 2) != 0) write_reg(ads_pkg::REG_ADV_X, pick_coef());
      if ($urandom_range(0, 2) != 0) write_reg(ads_pkg::REG_ADV_Y, pick_coef());
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      // A wider row is only allowed from the top of a frame, so the line buffers
      // are always filled before they are read.
      if ($urandom_range(0, 2) != 0 &&
          (sb.row == 0 || sb.clamp_width(w) <= sb.clamp_width(sb.width_reg)))
        write_reg(ads_pkg::REG_WIDTH, geometry_word(ads_pkg::REG_WIDTH, w));
      if ($urandom_range(0, 2) != 0)
        write_reg(ads_pkg::REG_HEIGHT,
                  geometry_word(ads_pkg::REG_HEIGHT, $urandom_range(0, 10)));
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_HI, $urandom);
      cfg_valid <= 1'b0;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, sb.frame_remainder());
      else n = sb.frame_remainder() + $urandom_range(0, 2) * sb.frame_size();
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      feed(n);
      random_items += n;
      wait_idle();
    end

    n = 0;
    while (sb.pending() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Streamed %0d samples and checked %0d results over %0d register writes,",
             sb.samples, sb.checked, sb.writes);
    $display("covering clamped, oversized, shrunk mid-frame and tallest grid geometries.");
    if (sb.errors == 0) begin
      $display("** advection_diffusion_stencil: PASSED **");
    end else begin
      $display("** advection_diffusion_stencil: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("** advection_diffusion_stencil: FAILED **");
    $finish;
  end

endmodule

// ===== advection_diffusion_stencil.f =====
rtl/ads_pkg.sv
rtl/ads_line_buf.sv
rtl/ads_rhs_core.sv
rtl/ads_out_fifo.sv
rtl/advection_diffusion_stencil.sv
tb/sv/advection_diffusion_stencil_tb.sv
